// ===== src/psl_pkg.sv =====
// Shared constants and control types for the positional sequence list.
`timescale 1ns / 1ps
`default_nettype none

package psl_pkg;

    localparam int CAPACITY = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int OP_W     = 3;
    localparam int POS_W    = 6;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 3;

    localparam logic [POS_W-1:0] CAP_COUNT = POS_W'(CAPACITY);

    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 3'd2;
    localparam logic [OP_W-1:0] OP_GET    = 3'd3;
    localparam logic [OP_W-1:0] OP_LENGTH = 3'd4;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_FULL     = 3'd1;
    localparam logic [ST_W-1:0] ST_BAD_POS  = 3'd2;
    localparam logic [ST_W-1:0] ST_EMPTY    = 3'd3;
    localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic decode;
        logic xfer;
        logic write_val;
        logic finish;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic dec_read;
        logic dec_wrval;
        logic xfer_last;
        logic xfer_wrval;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== src/psl_in_if.sv =====
// Request channel: operation item with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface psl_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         opcode;
    logic [5:0]         position;
    logic signed [31:0] value;

    modport source (output valid, output opcode, output position, output value,
                    input ready);
    modport sink (input valid, input opcode, input position, input value,
                  output ready);
endinterface

`default_nettype wire

// ===== src/psl_out_if.sv =====
// Result channel: status, data and length item with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface psl_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] data_out;
    logic [5:0]         found_position;
    logic [5:0]         list_length;

    modport source (output valid, output status, output data_out,
                    output found_position, output list_length, input ready);
    modport sink (input valid, input status, input data_out,
                  input found_position, input list_length, output ready);
endinterface

`default_nettype wire

// ===== src/psl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module psl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== src/psl_ctrl.sv =====
// Controller state machine: sequences decode, read/transfer steps and result load.
`timescale 1ns / 1ps
`default_nettype none

module psl_ctrl
    import psl_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    typedef enum logic [5:0] {
        S_IDLE      = 6'b000001,
        S_DECODE    = 6'b000010,
        S_READ      = 6'b000100,
        S_XFER      = 6'b001000,
        S_WRITE_VAL = 6'b010000,
        S_FINISH    = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                cmd.decode = 1'b1;
                if (sts.dec_read)
                begin
                    state_next = S_READ;
                end
                else if (sts.dec_wrval)
                begin
                    state_next = S_WRITE_VAL;
                end
                else
                begin
                    state_next = S_FINISH;
                end
            end
            S_READ:
            begin
                state_next = S_XFER;
            end
            S_XFER:
            begin
                cmd.xfer = 1'b1;
                if (sts.xfer_wrval)
                begin
                    state_next = S_WRITE_VAL;
                end
                else if (sts.xfer_last)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_WRITE_VAL:
            begin
                cmd.write_val = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // hold until the result register is free
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== src/psl_dp.sv =====
// Datapath: operation registers, entry RAM, index counter, count and result register.
`timescale 1ns / 1ps
`default_nettype none

module psl_dp
    import psl_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cmd_t                    cmd,
    output sts_t                         sts,
    input  wire logic [OP_W-1:0]         opcode,
    input  wire logic [POS_W-1:0]        position,
    input  wire logic signed [VAL_W-1:0] value,
    input  wire logic                    res_ready,
    output logic                         res_valid,
    output logic [ST_W-1:0]              status,
    output logic signed [VAL_W-1:0]      data_out,
    output logic [POS_W-1:0]             found_position,
    output logic [POS_W-1:0]             list_length
);

    logic [OP_W-1:0]  op_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic [POS_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic [ST_W-1:0]  st_reg, st_next;
    logic [VAL_W-1:0] data_reg, data_next;
    logic [POS_W-1:0] found_reg, found_next;
    logic             out_valid_reg, out_valid_next;
    logic [ST_W-1:0]  out_st_reg;
    logic [VAL_W-1:0] out_data_reg;
    logic [POS_W-1:0] out_found_reg;
    logic [POS_W-1:0] out_len_reg;

    logic [POS_W-1:0]  pos_m1;
    logic [POS_W-1:0]  idx_p1;
    logic [POS_W-1:0]  idx_m1;
    logic              full;
    logic              empty;
    logic              bad_ins;
    logic              bad_pos;
    logic              at_first;
    logic              match;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [VAL_W-1:0]  ram_wdata;
    logic [VAL_W-1:0]  ram_rdata;

    assign pos_m1   = pos_reg - POS_W'(1);
    assign idx_p1   = idx_reg + POS_W'(1);
    assign idx_m1   = idx_reg - POS_W'(1);
    assign full     = (count_reg == CAP_COUNT);
    assign empty    = (count_reg == '0);
    assign bad_ins  = (pos_reg == '0)
                   || ({1'b0, pos_reg} > ({1'b0, count_reg} + (POS_W+1)'(1)));
    assign bad_pos  = (pos_reg == '0) || (pos_reg > count_reg);
    assign at_first = (idx_reg == pos_m1);
    assign match    = (ram_rdata == val_reg);

    psl_ram #(
        .WIDTH(VAL_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // RAM write port: shift steps and the final insert write
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_p1[ADDR_W-1:0];
        ram_wdata = ram_rdata;
        if (cmd.write_val)
        begin
            ram_we    = 1'b1;
            ram_waddr = pos_m1[ADDR_W-1:0];
            ram_wdata = val_reg;
        end
        else if (cmd.xfer && (op_reg == OP_INSERT))
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_p1[ADDR_W-1:0];
        end
        else if (cmd.xfer && (op_reg == OP_DELETE) && !at_first)
        begin
            ram_we    = 1'b1;
            ram_waddr = idx_m1[ADDR_W-1:0];
        end
    end

    // Decode and transfer status for the controller
    always_comb
    begin
        sts            = '0;
        sts.out_free   = !out_valid_reg || res_ready;
        sts.xfer_wrval = (op_reg == OP_INSERT) && at_first;
        case (op_reg)
            OP_INSERT:
            begin
                sts.dec_read  = !full && !bad_ins && (count_reg >= pos_reg);
                sts.dec_wrval = !full && !bad_ins && (count_reg < pos_reg);
            end
            OP_DELETE:
            begin
                sts.dec_read  = !empty && !bad_pos;
                sts.xfer_last = (idx_p1 == count_reg);
            end
            OP_FIND:
            begin
                sts.dec_read  = !empty;
                sts.xfer_last = match || (idx_p1 == count_reg);
            end
            OP_GET:
            begin
                sts.dec_read  = !bad_pos;
                sts.xfer_last = 1'b1;
            end
            default:
            begin
                sts.dec_read = 1'b0;
            end
        endcase
    end

    // Working registers
    always_comb
    begin
        idx_next   = idx_reg;
        st_next    = st_reg;
        data_next  = data_reg;
        found_next = found_reg;
        if (cmd.decode)
        begin
            st_next    = ST_OK;
            data_next  = '0;
            found_next = '0;
            idx_next   = pos_m1;
            case (op_reg)
                OP_INSERT:
                begin
                    idx_next = count_reg - POS_W'(1);
                    if (full)
                    begin
                        st_next = ST_FULL;
                    end
                    else if (bad_ins)
                    begin
                        st_next = ST_BAD_POS;
                    end
                end
                OP_DELETE:
                begin
                    if (empty)
                    begin
                        st_next = ST_EMPTY;
                    end
                    else if (bad_pos)
                    begin
                        st_next = ST_BAD_POS;
                    end
                end
                OP_FIND:
                begin
                    idx_next = '0;
                    st_next  = ST_NOTFOUND;
                end
                OP_GET:
                begin
                    if (bad_pos)
                    begin
                        st_next = ST_BAD_POS;
                    end
                end
                default:
                begin
                    st_next = ST_OK;
                end
            endcase
        end
        else if (cmd.xfer)
        begin
            case (op_reg)
                OP_INSERT:
                begin
                    idx_next = idx_m1;
                end
                OP_DELETE:
                begin
                    if (at_first)
                    begin
                        data_next = ram_rdata;
                    end
                    idx_next = idx_p1;
                end
                OP_FIND:
                begin
                    if (match)
                    begin
                        st_next    = ST_OK;
                        found_next = idx_p1;
                    end
                    idx_next = idx_p1;
                end
                OP_GET:
                begin
                    data_next = ram_rdata;
                end
                default:
                begin
                    idx_next = idx_reg;
                end
            endcase
        end
    end

    // Count after the operation
    always_comb
    begin
        count_next = count_reg;
        if (st_reg == ST_OK)
        begin
            if (op_reg == OP_INSERT)
            begin
                count_next = count_reg + POS_W'(1);
            end
            else if (op_reg == OP_DELETE)
            begin
                count_next = count_reg - POS_W'(1);
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (cmd.finish)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= opcode;
            pos_reg <= position;
            val_reg <= value;
        end
        idx_reg   <= idx_next;
        st_reg    <= st_next;
        data_reg  <= data_next;
        found_reg <= found_next;
        if (cmd.finish)
        begin
            out_st_reg    <= st_reg;
            out_data_reg  <= data_reg;
            out_found_reg <= found_reg;
            out_len_reg   <= count_next;
        end
    end

    assign res_valid      = out_valid_reg;
    assign status         = out_st_reg;
    assign data_out       = out_data_reg;
    assign found_position = out_found_reg;
    assign list_length    = out_len_reg;

endmodule

`default_nettype wire

// ===== src/positional_sequence_list.sv =====
// Positional sequence list top level: controller, datapath and channel wiring.
// Steps after the accepting edge: length, unused opcodes and errors go decode then finish; get
// goes decode, read, transfer, finish; insert and delete add a read and a transfer step for each
// entry from the position to the end, insert then writing the value; a find reads and compares
// entries until a match or the end. A waiting result holds the finish. One item at a time.
// Reset clears the count and result valid; entries are not cleared and need no sweep.
`timescale 1ns / 1ps
`default_nettype none

module positional_sequence_list
    import psl_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    psl_in_if.sink   request,
    psl_out_if.source result
);

    cmd_t cmd;
    sts_t sts;

    psl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (request.valid),
        .req_ready (request.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    psl_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .opcode         (request.opcode),
        .position       (request.position),
        .value          (request.value),
        .res_ready      (result.ready),
        .res_valid      (result.valid),
        .status         (result.status),
        .data_out       (result.data_out),
        .found_position (result.found_position),
        .list_length    (result.list_length)
    );

endmodule

`default_nettype wire
